### rtl/frrs_pkg.sv
package frrs_pkg;

  // Field widths of the request and result words.
  localparam int INDEX_W       = 11;
  localparam int VALUE_W       = 32;
  localparam int SUM_W         = 64;
  localparam int ACTIVE_SIZE_W = 11;

  // One memory entry holds a node of both trees: difference high, weighted low.
  localparam int ENTRY_W = 2 * SUM_W;

  // Default number of positions and reset value of the size register.
  localparam int unsigned DEF_MAX_POSITIONS = 1024;
  localparam logic [ACTIVE_SIZE_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

  // Request codes.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUM = 1'b1;

  // Request word.
  typedef struct packed {
    logic                      req_type;
    logic [INDEX_W-1:0]        left_index;
    logic [INDEX_W-1:0]        right_index;
    logic signed [VALUE_W-1:0] add_value;
  } frrs_in_t;

  // Result word.
  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } frrs_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_MUL,
    ST_ACC,
    ST_SUM,
    ST_DONE
  } frrs_state_t;

endpackage

### rtl/frrs_ram.sv
module frrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/frrs_seq.sv
module frrs_seq import frrs_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  frrs_in_t                         in_data,
  input  logic [ACTIVE_SIZE_W-1:0]         active_size,
  output logic                             res_valid,
  input  logic                             res_take,
  output frrs_out_t                        res_data,
  output logic                             mem_rd_en,
  output logic [$clog2(MAX_POSITIONS)-1:0] mem_rd_addr,
  input  logic [ENTRY_W-1:0]               mem_rd_data,
  output logic                             mem_wr_en,
  output logic [$clog2(MAX_POSITIONS)-1:0] mem_wr_addr,
  output logic [ENTRY_W-1:0]               mem_wr_data
);

  localparam int AW = $clog2(MAX_POSITIONS);
  // Node numbers reach twice the size before a walk stops.
  localparam int NW = $clog2(MAX_POSITIONS + 1) + 1;
  localparam int LW = 32 + NW;
  localparam logic [NW-1:0] MAX_NODE  = NW'(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

  frrs_state_t state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             query_r, query_nxt;
  logic             phase_r, phase_nxt;
  logic [NW-1:0]    left_r, left_nxt;
  logic [NW-1:0]    right_r, right_nxt;
  logic [NW-1:0]    cur_r, cur_nxt;
  logic [SUM_W-1:0] amt_r, amt_nxt;
  logic [SUM_W-1:0] amt_neg_r, amt_neg_nxt;
  logic [SUM_W-1:0] wl_r, wl_nxt;
  logic [SUM_W-1:0] wr_r, wr_nxt;
  logic [SUM_W-1:0] acc_d_r, acc_d_nxt;
  logic [SUM_W-1:0] acc_w_r, acc_w_nxt;
  logic [LW-1:0]    prod_lo_r, prod_lo_nxt;
  logic [31:0]      prod_hi_r, prod_hi_nxt;
  logic [SUM_W-1:0] part_r, part_nxt;
  logic [SUM_W-1:0] res_r, res_nxt;
  logic             err_r, err_nxt;

  // Range check and weight products of an arriving word.
  logic                    bad;
  logic [INDEX_W-1:0]      left_m1_in;
  logic signed [43:0]      wl_mul;
  logic signed [43:0]      wr_mul;
  logic [SUM_W-1:0]        amt_ext;

  assign left_m1_in = in_data.left_index - INDEX_W'(1);
  assign bad = (in_data.left_index == '0)
            || (in_data.left_index > in_data.right_index)
            || (in_data.right_index > active_size)
            || (32'(in_data.right_index) > 32'(MAX_POSITIONS));
  assign wl_mul  = $signed(in_data.add_value) * $signed({1'b0, left_m1_in});
  assign wr_mul  = $signed(in_data.add_value) * $signed({1'b0, in_data.right_index});
  assign amt_ext = {{(SUM_W-VALUE_W){in_data.add_value[VALUE_W-1]}}, in_data.add_value};

  // Node arithmetic of the tree walk.
  logic [NW-1:0]    start_node;
  logic             start_ok;
  logic [NW-1:0]    low_bit;
  logic [NW-1:0]    next_node;
  logic             next_ok;
  logic [NW-1:0]    k_sel;
  logic [SUM_W-1:0] delta_d;
  logic [SUM_W-1:0] delta_w;

  always_comb begin
    if (query_r) begin
      start_node = phase_r ? (left_r - NW'(1)) : right_r;
    end else begin
      start_node = phase_r ? (right_r + NW'(1)) : left_r;
    end
  end

  assign start_ok  = (start_node != '0) && (start_node <= MAX_NODE);
  assign low_bit   = cur_r & (~cur_r + NW'(1));
  assign next_node = query_r ? (cur_r - low_bit) : (cur_r + low_bit);
  assign next_ok   = (next_node != '0) && (next_node <= MAX_NODE);
  assign k_sel     = phase_r ? (left_r - NW'(1)) : right_r;
  assign delta_d   = phase_r ? amt_neg_r : amt_r;
  assign delta_w   = phase_r ? wr_r : wl_r;

  // Next state and memory control.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    query_nxt    = query_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    cur_nxt      = cur_r;
    amt_nxt      = amt_r;
    amt_neg_nxt  = amt_neg_r;
    wl_nxt       = wl_r;
    wr_nxt       = wr_r;
    acc_d_nxt    = acc_d_r;
    acc_w_nxt    = acc_w_r;
    prod_lo_nxt  = prod_lo_r;
    prod_hi_nxt  = prod_hi_r;
    part_nxt     = part_r;
    res_nxt      = res_r;
    err_nxt      = err_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = AW'(start_node - NW'(1));
    mem_wr_en    = 1'b0;
    mem_wr_addr  = AW'(cur_r - NW'(1));
    mem_wr_data  = '0;

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry of both trees a cycle.
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          query_nxt   = (in_data.req_type == REQ_SUM);
          phase_nxt   = 1'b0;
          left_nxt    = NW'(in_data.left_index);
          right_nxt   = NW'(in_data.right_index);
          amt_nxt     = amt_ext;
          amt_neg_nxt = SUM_W'(0) - amt_ext;
          wl_nxt      = {{(SUM_W-44){wl_mul[43]}}, wl_mul};
          wr_nxt      = SUM_W'(0) - {{(SUM_W-44){wr_mul[43]}}, wr_mul};
          err_nxt     = bad;
          res_nxt     = '0;
          if (in_data.req_type == REQ_SUM) begin
            state_nxt = bad ? ST_DONE : ST_PREP;
          end else if (!bad) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // Start a walk: read its first node.
        acc_d_nxt = '0;
        acc_w_nxt = '0;
        if (start_ok) begin
          mem_rd_en = 1'b1;
          cur_nxt   = start_node;
          state_nxt = ST_WALK;
        end else if (query_r) begin
          state_nxt = ST_MUL;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        // Node data arrives; accumulate or write back, and read the next node.
        if (query_r) begin
          acc_d_nxt = acc_d_r + mem_rd_data[ENTRY_W-1:SUM_W];
          acc_w_nxt = acc_w_r + mem_rd_data[SUM_W-1:0];
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_data = {mem_rd_data[ENTRY_W-1:SUM_W] + delta_d,
                         mem_rd_data[SUM_W-1:0] + delta_w};
        end
        if (next_ok) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(next_node - NW'(1));
          cur_nxt     = next_node;
        end else if (query_r) begin
          state_nxt = ST_MUL;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        // Difference prefix times position, in two 32-bit halves.
        prod_lo_nxt = LW'(acc_d_r[31:0]) * LW'(k_sel);
        prod_hi_nxt = acc_d_r[SUM_W-1:32] * 32'(k_sel);
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        part_nxt  = SUM_W'(prod_lo_r) + {prod_hi_r, 32'b0} - acc_w_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (!phase_r) begin
          res_nxt   = part_r;
          phase_nxt = 1'b1;
          state_nxt = ST_PREP;
        end else begin
          res_nxt   = res_r - part_r;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    query_r   <= query_nxt;
    phase_r   <= phase_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    cur_r     <= cur_nxt;
    amt_r     <= amt_nxt;
    amt_neg_r <= amt_neg_nxt;
    wl_r      <= wl_nxt;
    wr_r      <= wr_nxt;
    acc_d_r   <= acc_d_nxt;
    acc_w_r   <= acc_w_nxt;
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
    part_r    <= part_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
  end

  assign res_data.range_sum   = $signed(res_r);
  assign res_data.range_error = err_r;

endmodule

### rtl/fenwick_range_update_range_sum.sv
// Range-add / range-sum store over positions 1..active_size, kept as two
// binary indexed trees that share one memory entry per node.
// Input channel (in_valid/in_ready/in_data): one word per request. An add
// request gives no result; a sum request gives exactly one result word on
// the output channel (out_valid/out_ready/out_data). Invalid ranges are
// dropped for adds and answered with a zero sum and range_error for sums.
// The size register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce it.
// Each request is handled alone. A walk visits one tree node at a time, at
// most log2(MAX_POSITIONS)+1 nodes, as the tree memory has a single read
// port. An add runs two walks, from left_index and from right_index+1,
// before the next acceptance; a sum runs two prefix walks, from right_index
// and left_index-1, each followed by the multiply and accumulate steps.
// After reset a clearing pass zeroes the memory entry by entry, during
// which in_ready stays low.
// A finished result waits in the output register while out_ready is low; the
// block may accept and run the next word meanwhile, and a second result
// waits inside until the register frees.
module fenwick_range_update_range_sum import frrs_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  frrs_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output frrs_out_t                out_data,
  input  logic                     cfg_wr_en,
  input  logic [ACTIVE_SIZE_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_POSITIONS);

  logic [ACTIVE_SIZE_W-1:0] active_size_r, active_size_nxt;
  logic                     out_valid_r, out_valid_nxt;
  frrs_out_t                out_data_r, out_data_nxt;

  logic                     res_valid;
  logic                     res_take;
  frrs_out_t                res_data;
  logic                     mem_rd_en;
  logic [AW-1:0]            mem_rd_addr;
  logic [ENTRY_W-1:0]       mem_rd_data;
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr;
  logic [ENTRY_W-1:0]       mem_wr_data;

  // Tree memory: difference and weighted nodes side by side.
  frrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POSITIONS)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Request sequencer.
  frrs_seq #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .active_size (active_size_r),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // The output register takes a new word when empty or being emptied.
  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    active_size_nxt = cfg_wr_en ? cfg_wr_data : active_size_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= ACTIVE_SIZE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      active_size_r <= active_size_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb_fenwick_range_update_range_sum.sv
`timescale 1ns / 100ps

module tb_fenwick_range_update_range_sum import frrs_pkg::*; ;

  localparam int unsigned MAX_POS    = DEF_MAX_POSITIONS;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASES = 8;

  // Shadow copy of both trees and the size register; predicts the result words.
  class fenwick_sum_board;
    logic [63:0] diff_nodes [1:MAX_POS];
    logic [63:0] wgt_nodes [1:MAX_POS];
    logic [ACTIVE_SIZE_W-1:0] size_reg;
    frrs_out_t pending_sums [$];
    int mismatches;

    function new();
      foreach (diff_nodes[i]) begin
        diff_nodes[i] = '0;
        wgt_nodes[i]  = '0;
      end
      size_reg   = ACTIVE_SIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_size(logic [ACTIVE_SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // Oversized register values behave as the full tree.
    function int unsigned usable_size();
      return (size_reg > MAX_POS) ? MAX_POS : 32'(size_reg);
    endfunction

    // Point update; always climbs to the top of the tree.
    function void node_add(bit weighted, int unsigned pos, logic [63:0] amount);
      int unsigned i;
      i = pos;
      while (i >= 1 && i <= MAX_POS) begin
        if (weighted) wgt_nodes[i] += amount;
        else diff_nodes[i] += amount;
        i += i & (~i + 1);
      end
    endfunction

    function logic [63:0] node_prefix(bit weighted, int unsigned pos);
      logic [63:0] acc;
      int unsigned i;
      acc = '0;
      i = (pos > MAX_POS) ? MAX_POS : pos;
      while (i != 0) begin
        acc += weighted ? wgt_nodes[i] : diff_nodes[i];
        i -= i & (~i + 1);
      end
      return acc;
    endfunction

    // Sum of elements 1..k, modulo 2^64.
    function logic [63:0] element_total(int unsigned k);
      return node_prefix(1'b0, k) * 64'(k) - node_prefix(1'b1, k);
    endfunction

    // Apply an accepted request word; a sum request queues its expected result.
    function void note_request(frrs_in_t w);
      int unsigned lo, hi;
      logic [63:0] amount;
      bit bad;
      frrs_out_t want;
      lo = 32'(w.left_index);
      hi = 32'(w.right_index);
      bad = (lo == 0) || (lo > hi) || (hi > usable_size());
      amount = {{32{w.add_value[VALUE_W-1]}}, w.add_value};
      if (w.req_type == REQ_ADD) begin
        if (!bad) begin
          node_add(1'b0, lo, amount);
          node_add(1'b0, hi + 1, -amount);
          node_add(1'b1, lo, amount * 64'(lo - 1));
          node_add(1'b1, hi + 1, (-amount) * 64'(hi));
        end
      end else begin
        if (bad) begin
          want.range_sum   = '0;
          want.range_error = 1'b1;
        end else begin
          want.range_sum   = element_total(hi) - element_total(lo - 1);
          want.range_error = 1'b0;
        end
        pending_sums.push_back(want);
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare a result word with the oldest expected sum.
    task check_sum(frrs_out_t got);
      frrs_out_t want;
      if (pending_sums.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word sum=%h error=%b",
                                got.range_sum, got.range_error));
        return;
      end
      want = pending_sums.pop_front();
      if (got.range_sum !== want.range_sum)
        flag_mismatch($sformatf("range_sum got %h, wanted %h", got.range_sum, want.range_sum));
      if (got.range_error !== want.range_error)
        flag_mismatch($sformatf("range_error got %b, wanted %b",
                                got.range_error, want.range_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  frrs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frrs_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [ACTIVE_SIZE_W-1:0] cfg_wr_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  fenwick_sum_board sb = new();

  fenwick_range_update_range_sum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_sum(out_data);
    end
  end

  // Give up when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** fenwick_range_update_range_sum: FAILED **");
      $finish;
    end
  end

  // Present one request word and hold it until accepted.
  task automatic send_word(frrs_in_t w);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_req(logic kind, int unsigned lo, int unsigned hi, logic [31:0] value);
    frrs_in_t w;
    w.req_type    = kind;
    w.left_index  = INDEX_W'(lo);
    w.right_index = INDEX_W'(hi);
    w.add_value   = value;
    send_word(w);
  endtask

  // Drain, let any add finish its walk, then write the size register.
  task automatic write_size(logic [ACTIVE_SIZE_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(value);
  endtask

  // Mostly well-formed ranges inside the active size, some raw noise.
  function automatic frrs_in_t make_request(int unsigned lim, output bit counts);
    frrs_in_t w;
    w.req_type = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: w.add_value = 32'h7FFF_FFFF;
      1: w.add_value = 32'h8000_0000;
      2: w.add_value = $urandom_range(16) - 8;
      default: w.add_value = $urandom();
    endcase
    if (lim == 0 || $urandom_range(99) < 12) begin
      w.left_index  = INDEX_W'($urandom());
      w.right_index = INDEX_W'($urandom());
      counts = (w.req_type == REQ_SUM);
    end else begin
      w.left_index  = INDEX_W'($urandom_range(lim, 1));
      w.right_index = ($urandom_range(3) == 0) ? w.left_index
                                               : INDEX_W'($urandom_range(lim, w.left_index));
      counts = 1'b1;
    end
    return w;
  endfunction

  initial begin
    frrs_in_t w;
    bit counts;
    int done;
    int target;
    logic [ACTIVE_SIZE_W-1:0] phase_size [PHASES];

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset size.
    send_req(REQ_SUM, 1, 1024, 32'h0);
    send_req(REQ_ADD, 1, 1024, 32'h7FFF_FFFF);
    send_req(REQ_ADD, 1, 1, 32'h8000_0000);
    send_req(REQ_ADD, 1024, 1024, 32'hFFFF_FFFF);
    send_req(REQ_ADD, 5, 5, 32'd100);          // initial values as single positions
    send_req(REQ_ADD, 6, 6, -32'sd100);
    send_req(REQ_SUM, 1, 1, 32'h0);
    send_req(REQ_SUM, 1024, 1024, 32'h0);
    send_req(REQ_SUM, 1, 1024, 32'h0);
    send_req(REQ_SUM, 5, 6, 32'h0);
    send_req(REQ_SUM, 512, 513, 32'hFFFF_FFFF);
    send_req(REQ_SUM, 0, 5, 32'h0);            // left index of zero
    send_req(REQ_ADD, 0, 5, 32'd7);
    send_req(REQ_ADD, 7, 3, 32'd9);            // left beyond right
    send_req(REQ_SUM, 7, 3, 32'h0);
    send_req(REQ_SUM, 1, 1025, 32'h0);         // right beyond the active size
    send_req(REQ_SUM, 2047, 2047, 32'h0);
    send_req(REQ_ADD, 1000, 2047, 32'd3);
    send_req(REQ_SUM, 1024, 1024, 32'h0);
    send_req(REQ_ADD, 1, 1024, 32'h8000_0000); // pushes the totals round the wrap
    send_req(REQ_ADD, 1, 1024, 32'h8000_0000);
    send_req(REQ_SUM, 1, 1024, 32'h0);
    send_req(REQ_SUM, 1023, 1024, 32'h0);

    // Random phases over several sizes and idling patterns.
    phase_size[0] = 11'd1024;
    phase_size[1] = 11'd1;
    phase_size[2] = 11'd2047;
    phase_size[3] = 11'd0;
    phase_size[4] = ACTIVE_SIZE_W'($urandom_range(64, 3));
    phase_size[5] = 11'd2;
    phase_size[6] = ACTIVE_SIZE_W'($urandom_range(1023, 65));
    phase_size[7] = 11'd1024;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      write_size(phase_size[p]);
      target = (phase_size[p] == 0) ? 30 : 100;
      done = 0;
      while (done < target) begin
        w = make_request(sb.usable_size(), counts);
        send_word(w);
        if (counts) done++;
      end
    end

    // Drain and let the last walk finish.
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.pending_sums.size() != 0)
      sb.flag_mismatch($sformatf("%0d expected sums never arrived", sb.pending_sums.size()));
    if (sb.mismatches == 0) begin
      $display("** fenwick_range_update_range_sum: PASSED **");
    end else begin
      $display("** fenwick_range_update_range_sum: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/frrs_pkg.sv
rtl/frrs_ram.sv
rtl/frrs_seq.sv
rtl/fenwick_range_update_range_sum.sv
dv/tb_fenwick_range_update_range_sum.sv
